### hdl/tkr_pkg.sv
// Package for the top-k ranking block: item structs, entry and cell-control types.
// No dependencies; used by tkr_cell and top_k_ranking_with_dedup.
package tkr_pkg;

    typedef struct packed {
        logic        mode;
        logic [31:0] item_id;
        logic [31:0] item_score;
    } t_in_item;

    typedef struct packed {
        logic [31:0] rank_id;
        logic [31:0] rank_score;
        logic        last_rank;
    } t_out_item;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] score;
    } t_entry;

    // Per-cycle command shared by every cell of the chain
    typedef struct packed {
        logic cmp;   // compare offer against stored entry, latch flags
        logic upd;   // apply insert / move-up using latched flags
        logic rot;   // rotate chain toward rank 0 for readout
    } t_cell_ctl;

    localparam logic MODE_OFFER   = 1'b0;
    localparam logic MODE_READOUT = 1'b1;

endpackage

### hdl/tkr_cell.sv
// One rank slot of the ranking chain: stored entry, offer compare flags, update mux.
// Depends on tkr_pkg.
module tkr_cell import tkr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_offer,
    input  t_entry    i_left,      // entry of rank i-1
    input  logic      i_left_eb,   // rank i-1 is beaten and shifts down
    input  t_entry    i_right,     // entry of rank i+1 (readout rotation)
    input  logic      i_m_above,   // id matched at some rank < i
    input  logic      i_mb,        // id matched at some rank > i
    input  logic      i_rb,        // raised match at some rank > i
    output t_entry    o_entry,
    output logic      o_eb,
    output logic      o_m_above,
    output logic      o_mb,
    output logic      o_rb
);

    t_entry r_entry;
    logic   r_match;
    logic   r_beat;

    logic   w_found;
    logic   w_nomatch;
    logic   w_take;

    always_comb begin
        w_found   = r_match && !i_m_above;
        w_nomatch = !i_m_above && !r_match && !i_mb;
        // only ranks above the insertion limit take part
        o_eb      = r_beat && (w_nomatch || i_rb);
        w_take    = o_eb || (w_found && r_beat);
        o_m_above = i_m_above || r_match;
        o_mb      = i_mb || r_match;
        o_rb      = i_rb || (w_found && r_beat);
        o_entry   = r_entry;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= (i_offer.id == r_entry.id);
            r_beat  <= (i_offer.score > r_entry.score) ||
                       ((i_offer.score == r_entry.score) && (i_offer.id < r_entry.id));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_ctl.rot) begin
            r_entry <= i_right;
        end else if (i_ctl.upd) begin
            if (i_left_eb) begin
                r_entry <= i_left;
            end else if (w_take) begin
                r_entry <= i_offer;
            end
        end
    end

endmodule

### hdl/top_k_ranking_with_dedup.sv
// Top-k ranking with dedup: an offer is compared when it is accepted and then updated in ST_UPD,
// with busy high during the update. A readout keeps busy high through ST_READ, one result per
// cycle through the o_result register, and no new item is accepted until it is through. The chain
// rotates toward rank 0 and ends back in place.
// Rate is set by the registered compare flags in each cell and by the rotation shift.
// Synchronous active-low reset clears all ranks to (0,0); results cannot be stalled.
module top_k_ranking_with_dedup import tkr_pkg::*; #(
    parameter int RANK_DEPTH = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int CW = (RANK_DEPTH > 1) ? $clog2(RANK_DEPTH) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_UPD, ST_READ} t_state;

    t_state    r_state;
    logic [CW-1:0] r_cnt;
    t_entry    r_offer;

    logic      w_accept;
    t_cell_ctl w_ctl;
    t_entry    w_offer;

    t_entry    w_entry [RANK_DEPTH];
    logic      w_eb    [RANK_DEPTH];
    logic      w_mab   [RANK_DEPTH];
    logic      w_mb    [RANK_DEPTH];
    logic      w_rb    [RANK_DEPTH];

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    always_comb begin
        w_ctl.cmp = w_accept && (i_item.mode == MODE_OFFER);
        w_ctl.upd = (r_state == ST_UPD);
        w_ctl.rot = (r_state == ST_READ);
        if (r_state == ST_UPD) begin
            w_offer = r_offer;
        end else begin
            w_offer.id    = i_item.item_id;
            w_offer.score = i_item.item_score;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < RANK_DEPTH; gi++) begin : g_cell
            t_entry w_l;
            logic   w_leb;
            logic   w_imab;
            t_entry w_r;
            logic   w_imb;
            logic   w_irb;

            if (gi == 0) begin : g_first
                assign w_l    = '0;
                assign w_leb  = 1'b0;
                assign w_imab = 1'b0;
            end else begin : g_mid
                assign w_l    = w_entry[gi-1];
                assign w_leb  = w_eb[gi-1];
                assign w_imab = w_mab[gi-1];
            end

            if (gi == RANK_DEPTH - 1) begin : g_last
                assign w_r   = w_entry[0];
                assign w_imb = 1'b0;
                assign w_irb = 1'b0;
            end else begin : g_inner
                assign w_r   = w_entry[gi+1];
                assign w_imb = w_mb[gi+1];
                assign w_irb = w_rb[gi+1];
            end

            tkr_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_offer   (w_offer),
                .i_left    (w_l),
                .i_left_eb (w_leb),
                .i_right   (w_r),
                .i_m_above (w_imab),
                .i_mb      (w_imb),
                .i_rb      (w_irb),
                .o_entry   (w_entry[gi]),
                .o_eb      (w_eb[gi]),
                .o_m_above (w_mab[gi]),
                .o_mb      (w_mb[gi]),
                .o_rb      (w_rb[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_ctl.cmp) begin
            r_offer.id    <= i_item.item_id;
            r_offer.score <= i_item.item_score;
        end
        o_result.rank_id    <= w_entry[0].id;
        o_result.rank_score <= w_entry[0].score;
        o_result.last_rank  <= (r_state == ST_READ) && (r_cnt == CW'(RANK_DEPTH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cnt <= '0;
                        if (i_item.mode == MODE_READOUT) begin
                            r_state <= ST_READ;
                        end else begin
                            r_state <= ST_UPD;
                        end
                    end
                end
                ST_UPD: begin
                    r_state <= ST_IDLE;
                end
                ST_READ: begin
                    o_strobe <= 1'b1;
                    if (r_cnt == CW'(RANK_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_strobe_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_READ))
        else $error("result strobe without readout");

    a_last_ends_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_rank) |-> (r_state == ST_IDLE))
        else $error("readout continues past last rank");

    a_upd_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |=> (r_state == ST_IDLE))
        else $error("update phase longer than one cycle");

    a_offer_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.cmp |=> (r_state == ST_UPD))
        else $error("offer accepted without update phase");

endmodule

### verif/top_k_ranking_with_dedup_tb.sv
// Testbench for top_k_ranking_with_dedup: directed table, then random offers and readouts,
// each readout checked rank by rank against an in-bench model of the ranking or typed-in values.
// Depends on tkr_pkg and the top_k_ranking_with_dedup RTL.
`timescale 1ns / 100ps

module top_k_ranking_with_dedup_tb;
    import tkr_pkg::*;

    localparam int RANK_DEPTH  = 20;
    localparam int RAND_ITEMS  = 250;
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_REPORTS = 10;

    // How a readout row of the table is checked
    typedef enum logic [1:0] {
        CHK_PRED  = 2'd0,  // all ranks from the ranking model
        CHK_EMPTY = 2'd1,  // typed in: every rank (0,0)
        CHK_TOP   = 2'd2   // typed in: rank 0 equals the row's id/score fields
    } t_chk;

    typedef struct packed {
        t_chk     chk;
        t_in_item item;
    } t_row;

    localparam int DIR_ROWS = 21;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;
    t_chk      row_chk;

    t_entry    ranking [RANK_DEPTH];
    t_out_item exp_ranks [$];
    int        fail_cnt  = 0;
    int        cycle_cnt = 0;
    t_row      dir_rows [DIR_ROWS];

    top_k_ranking_with_dedup #(
        .RANK_DEPTH(RANK_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Slots top-1 down to 0; every slot the offer beats moves down one rank.
    task automatic sink_into(input logic [31:0] id, input logic [31:0] score, input int top);
        for (int i = top - 1; i >= 0; i--) begin
            if (score > ranking[i].score ||
                (score == ranking[i].score && id < ranking[i].id)) begin
                if (i + 1 < RANK_DEPTH)
                    ranking[i + 1] = ranking[i];
                ranking[i].id    = id;
                ranking[i].score = score;
            end
        end
    endtask

    task automatic rank_offer(input logic [31:0] id, input logic [31:0] score);
        int hit;
        hit = -1;
        for (int i = 0; i < RANK_DEPTH; i++) begin
            if (hit < 0 && ranking[i].id == id)
                hit = i;
        end
        if (hit < 0) begin
            sink_into(id, score, RANK_DEPTH);
        end else if (ranking[hit].score < score) begin
            ranking[hit].score = score;
            sink_into(id, score, hit);
        end
    endtask

    // Result check, then prediction for the item accepted at this edge
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (exp_ranks.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("unexpected result: id=%h score=%h last=%b",
                                 o_result.rank_id, o_result.rank_score, o_result.last_rank);
                end else begin
                    want = exp_ranks.pop_front();
                    if (o_result.rank_id !== want.rank_id ||
                        o_result.rank_score !== want.rank_score ||
                        o_result.last_rank !== want.last_rank) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS)
                            $display("mismatch: exp id=%h score=%h last=%b, got id=%h score=%h last=%b",
                                     want.rank_id, want.rank_score, want.last_rank,
                                     o_result.rank_id, o_result.rank_score, o_result.last_rank);
                    end
                end
            end
            if (start && !busy) begin
                if (i_item.mode == MODE_OFFER) begin
                    rank_offer(i_item.item_id, i_item.item_score);
                end else begin
                    for (int r = 0; r < RANK_DEPTH; r++) begin
                        want.rank_id    = ranking[r].id;
                        want.rank_score = ranking[r].score;
                        want.last_rank  = (r == RANK_DEPTH - 1);
                        if (row_chk == CHK_EMPTY) begin
                            want.rank_id    = '0;
                            want.rank_score = '0;
                        end else if (row_chk == CHK_TOP && r == 0) begin
                            want.rank_id    = i_item.item_id;
                            want.rank_score = i_item.item_score;
                        end
                        exp_ranks.push_back(want);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("[top_k_ranking_with_dedup] ERROR");
            $finish;
        end
    end

    // Returns at the edge that accepts the item
    task automatic send_item(input t_in_item it, input t_chk chk, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_item  <= it;
        row_chk <= chk;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic int idle_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int       r;
        it.item_id    = $urandom;
        it.item_score = $urandom;
        if ($urandom_range(0, 7) == 0) begin
            it.mode = MODE_READOUT;
            return it;
        end
        it.mode = MODE_OFFER;
        // small id pool keeps duplicates and evictions frequent
        r = $urandom_range(0, 99);
        if (r < 75)
            it.item_id = $urandom_range(1, 40);
        else if (r < 77)
            it.item_id = '0;
        else if (r < 80)
            it.item_id = 32'hFFFF_FFFF;
        r = $urandom_range(0, 99);
        if (r < 40)
            it.item_score = $urandom_range(0, 64);
        else if (r < 50)
            it.item_score = 32'hFFFF_FFFF - $urandom_range(0, 3);
        else if (r < 60)
            it.item_score = $urandom_range(0, 3);
        return it;
    endfunction

    initial begin
        bit calm;
        start   = 1'b0;
        i_item  = '0;
        row_chk = CHK_PRED;
        i_rst_n = 1'b0;
        for (int i = 0; i < RANK_DEPTH; i++)
            ranking[i] = '0;

        dir_rows = '{
            {CHK_EMPTY, MODE_READOUT, 32'hFFFF_FFFF, 32'h1234_5678},
            {CHK_PRED,  MODE_OFFER,   32'd1,         32'd0},          // zero score
            {CHK_PRED,  MODE_OFFER,   32'd0,         32'd0},          // reserved id, no raise
            {CHK_EMPTY, MODE_READOUT, 32'd0,         32'd0},
            {CHK_PRED,  MODE_OFFER,   32'hFFFF_FFFF, 32'hFFFF_FFFF},
            {CHK_TOP,   MODE_READOUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
            {CHK_PRED,  MODE_OFFER,   32'd5,         32'd100},
            {CHK_PRED,  MODE_OFFER,   32'd3,         32'd100},        // tie, smaller id first
            {CHK_PRED,  MODE_OFFER,   32'd7,         32'd100},
            {CHK_PRED,  MODE_OFFER,   32'd5,         32'd50},         // ranked, lower score
            {CHK_PRED,  MODE_OFFER,   32'd5,         32'd100},        // ranked, equal score
            {CHK_PRED,  MODE_OFFER,   32'd7,         32'd200},        // ranked, raised
            {CHK_PRED,  MODE_OFFER,   32'd0,         32'd10},         // reserved id, takes empty
            {CHK_PRED,  MODE_OFFER,   32'd1,         32'hFFFF_FFFF},  // tie with top entry
            {CHK_TOP,   MODE_READOUT, 32'd1,         32'hFFFF_FFFF},
            {CHK_PRED,  MODE_OFFER,   32'h8000_0000, 32'd1},
            {CHK_PRED,  MODE_OFFER,   32'h7FFF_FFFF, 32'hFFFF_FFFE},
            {CHK_PRED,  MODE_OFFER,   32'd3,         32'hFFFF_FFFF},  // raised to max
            {CHK_PRED,  MODE_READOUT, 32'h5555_5555, 32'hAAAA_AAAA},
            {CHK_PRED,  MODE_OFFER,   32'd2,         32'd0},
            {CHK_PRED,  MODE_READOUT, 32'd0,         32'd0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_item(dir_rows[k].item, dir_rows[k].chk, idle_gap(1'b0));

        calm = 1'b0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 30 == 0)
                calm = ($urandom_range(0, 2) == 0);
            send_item(rand_item(), CHK_PRED, idle_gap(calm));
        end
        // last readout so the final state is seen
        send_item({MODE_READOUT, 32'd0, 32'd0}, CHK_PRED, 0);
        start <= 1'b0;

        while (exp_ranks.size() != 0) @(posedge i_clk);
        repeat (RANK_DEPTH + 5) @(posedge i_clk);
        fail_cnt += exp_ranks.size();

        if (fail_cnt == 0) begin
            $display("[top_k_ranking_with_dedup] OK");
        end else begin
            $display("[top_k_ranking_with_dedup] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hdl/tkr_pkg.sv
hdl/tkr_cell.sv
hdl/top_k_ranking_with_dedup.sv
verif/top_k_ranking_with_dedup_tb.sv
